[design/tgarle_pkg.sv]
`timescale 1ns / 1ps

package tgarle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 8;

    // configuration register indexes
    localparam logic CFG_PIXEL_MODE  = 1'b0;
    localparam logic CFG_PIXEL_TOTAL = 1'b1;

    localparam logic MODE_INDEXED   = 1'b0;
    localparam logic MODE_TRUECOLOR = 1'b1;

    localparam logic [WORD_W-1:0] PIXEL_TOTAL_RESET = 32'd4096;

    // transparent key color and alpha codes
    localparam logic [BYTE_W-1:0] KEY_B        = 8'd255;
    localparam logic [BYTE_W-1:0] KEY_G        = 8'd0;
    localparam logic [BYTE_W-1:0] KEY_R        = 8'd255;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

    // position of a truecolor byte within its pixel
    typedef enum logic [1:0] {
        PIX_BLUE  = 2'd0,
        PIX_GREEN = 2'd1,
        PIX_RED   = 2'd2
    } pix_byte_t;

    typedef struct packed {
        logic [WORD_W-1:0]  pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic [WORD_W-1:0]  first_position;
        logic               image_done;
        logic               overrun;
    } result_t;

endpackage

[design/tga_rle_pixel_decoder_core.sv]
`timescale 1ns / 1ps
// a result is registered in the output register, or the skid stage if the output stalls
// one byte per cycle while not stalled; header and leading color bytes give no result
// the output register plus a one-word skid stage keep bytes flowing while results wait
// rst_n clears the parser to expect a packet header, pixel_mode to truecolor and
// pixel_total to 4096, and empties the output stages
module tga_rle_pixel_decoder_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tgarle_pkg::WORD_W-1:0] cfg_data,

    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  logic [tgarle_pkg::BYTE_W-1:0] data_byte,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tgarle_pkg::WORD_W-1:0]  pixel_value,
    output logic [tgarle_pkg::COUNT_W-1:0] repeat_count,
    output logic [tgarle_pkg::WORD_W-1:0]  first_position,
    output logic                          image_done,
    output logic                          overrun
);
    import tgarle_pkg::*;

    logic                pixel_mode_reg;
    logic [WORD_W-1:0]   pixel_total_reg;

    logic                expect_header_reg, expect_header_next;
    logic                packet_is_run_reg, packet_is_run_next;
    logic [COUNT_W-1:0]  pixels_left_reg, pixels_left_next;
    pix_byte_t           byte_in_pixel_reg, byte_in_pixel_next;
    logic [2*BYTE_W-1:0] partial_color_reg, partial_color_next;
    logic [WORD_W-1:0]   pixels_done_reg, pixels_done_next;

    result_t             out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;

    logic                accept;
    logic                produce;
    result_t             result;

    logic [WORD_W-1:0]   total;
    logic [WORD_W-1:0]   remaining;
    logic [COUNT_W-1:0]  repeat_cnt;
    logic                over;
    logic                done;
    logic                pixel_ready;
    logic [WORD_W-1:0]   value;
    logic [BYTE_W-1:0]   alpha;

    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        total     = (pixel_total_reg == '0) ? WORD_W'(1) : pixel_total_reg;
        remaining = (pixels_done_reg >= total) ? WORD_W'(1) : total - pixels_done_reg;

        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        pixels_left_next   = pixels_left_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        partial_color_next = partial_color_reg;
        pixels_done_next   = pixels_done_reg;

        pixel_ready = 1'b0;
        value       = '0;
        alpha       = ALPHA_OPAQUE;
        repeat_cnt  = '0;
        over        = 1'b0;
        done        = 1'b0;

        if (expect_header_reg)
        begin
            packet_is_run_next = data_byte[BYTE_W-1];
            pixels_left_next   = {1'b0, data_byte[BYTE_W-2:0]} + COUNT_W'(1);
            byte_in_pixel_next = PIX_BLUE;
            expect_header_next = 1'b0;
        end
        else if (pixel_mode_reg == MODE_INDEXED)
        begin
            value              = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
            byte_in_pixel_next = PIX_BLUE;
            pixel_ready        = 1'b1;
        end
        else
        begin
            case (byte_in_pixel_reg)
                PIX_BLUE:
                begin
                    partial_color_next = {BYTE_W'(0), data_byte};
                    byte_in_pixel_next = PIX_GREEN;
                end
                PIX_GREEN:
                begin
                    partial_color_next = {data_byte, partial_color_reg[BYTE_W-1:0]};
                    byte_in_pixel_next = PIX_RED;
                end
                default:
                begin
                    if (partial_color_reg[BYTE_W-1:0] == KEY_B
                        && partial_color_reg[2*BYTE_W-1:BYTE_W] == KEY_G
                        && data_byte == KEY_R)
                        alpha = ALPHA_CLEAR;
                    value              = {alpha, data_byte, partial_color_reg};
                    byte_in_pixel_next = PIX_BLUE;
                    pixel_ready        = 1'b1;
                end
            endcase
        end

        if (pixel_ready)
        begin
            if (packet_is_run_reg)
            begin
                // clip a run that reaches past the last pixel
                if (WORD_W'(pixels_left_reg) > remaining)
                begin
                    repeat_cnt = remaining[COUNT_W-1:0];
                    over       = 1'b1;
                end
                else
                begin
                    repeat_cnt = pixels_left_reg;
                end
                pixels_left_next = '0;
            end
            else
            begin
                repeat_cnt       = COUNT_W'(1);
                over             = (remaining == WORD_W'(1)) && (pixels_left_reg > COUNT_W'(1));
                pixels_left_next = pixels_left_reg - COUNT_W'(1);
            end
            done = (WORD_W'(repeat_cnt) == remaining);

            if (done)
            begin
                pixels_done_next   = '0;
                pixels_left_next   = '0;
                expect_header_next = 1'b1;
            end
            else
            begin
                pixels_done_next = pixels_done_reg + WORD_W'(repeat_cnt);
                if (pixels_left_next == '0)
                    expect_header_next = 1'b1;
            end
        end

        result.pixel_value    = value;
        result.repeat_count   = repeat_cnt;
        result.first_position = pixels_done_reg;
        result.image_done     = done;
        result.overrun        = over;

        produce = accept && pixel_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg  <= MODE_TRUECOLOR;
            pixel_total_reg <= PIXEL_TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_MODE:  pixel_mode_reg  <= cfg_data[0];
                CFG_PIXEL_TOTAL: pixel_total_reg <= cfg_data;
                default:         pixel_mode_reg  <= pixel_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            pixels_left_reg   <= '0;
            byte_in_pixel_reg <= PIX_BLUE;
            partial_color_reg <= '0;
            pixels_done_reg   <= '0;
        end
        else if (accept)
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            pixels_left_reg   <= pixels_left_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            partial_color_reg <= partial_color_next;
            pixels_done_reg   <= pixels_done_next;
        end
    end

    // output register with a one-word skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
            else if (produce)
            begin
                out_reg <= result;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (produce)
            begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (produce)
        begin
            out_reg       <= result;
            out_valid_reg <= 1'b1;
        end
    end

    assign result_valid   = out_valid_reg;
    assign pixel_value    = out_reg.pixel_value;
    assign repeat_count   = out_reg.repeat_count;
    assign first_position = out_reg.first_position;
    assign image_done     = out_reg.image_done;
    assign overrun        = out_reg.overrun;

endmodule

[bench/tga_rle_checker.sv]
`timescale 1ns / 1ps

module tga_rle_checker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [tgarle_pkg::WORD_W-1:0]  cfg_data,

    input  logic                           byte_valid,
    input  logic                           byte_stall,
    input  logic [tgarle_pkg::BYTE_W-1:0]  data_byte,

    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic [tgarle_pkg::WORD_W-1:0]  pixel_value,
    input  logic [tgarle_pkg::COUNT_W-1:0] repeat_count,
    input  logic [tgarle_pkg::WORD_W-1:0]  first_position,
    input  logic                           image_done,
    input  logic                           overrun,

    output int                             fail_count,
    output int                             pending
);

    import tgarle_pkg::*;

    // decoder state as the stream walks through it
    logic              want_header;
    logic              run_packet;
    logic [7:0]        packet_left;
    pix_byte_t         color_phase;
    logic [15:0]       color_lo;
    logic [WORD_W-1:0] position;
    logic              mode_q;
    logic [WORD_W-1:0] total_q;

    result_t expected_pixels[$];
    int      errors;

    task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    endtask

    task automatic check_result();
        result_t want;
        if (expected_pixels.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result expected none actual value %h repeat %0d pos %0d",
                     $time, pixel_value, repeat_count, first_position);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (want.pixel_value !== pixel_value)
                report_field("pixel_value", want.pixel_value, pixel_value);
            if (want.repeat_count !== repeat_count)
                report_field("repeat_count", {24'd0, want.repeat_count}, {24'd0, repeat_count});
            if (want.first_position !== first_position)
                report_field("first_position", want.first_position, first_position);
            if (want.image_done !== image_done)
                report_field("image_done", {31'd0, want.image_done}, {31'd0, image_done});
            if (want.overrun !== overrun)
                report_field("overrun", {31'd0, want.overrun}, {31'd0, overrun});
        end
    endtask

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] eff_total;
        logic [WORD_W-1:0] remaining;
        logic [WORD_W-1:0] reps;
        logic [BYTE_W-1:0] alpha;
        logic              clipped;
        logic              last;
        result_t           res;

        if (want_header)
        begin
            run_packet  = b[7];
            packet_left = {1'b0, b[6:0]} + 8'd1;
            color_phase = PIX_BLUE;
            want_header = 1'b0;
            return;
        end

        if (mode_q == MODE_INDEXED)
        begin
            value       = {24'd0, b};
            color_phase = PIX_BLUE;
        end
        else if (color_phase == PIX_BLUE)
        begin
            color_lo    = {8'h00, b};
            color_phase = PIX_GREEN;
            return;
        end
        else if (color_phase == PIX_GREEN)
        begin
            color_lo[15:8] = b;
            color_phase    = PIX_RED;
            return;
        end
        else
        begin
            alpha = (color_lo[7:0] == KEY_B && color_lo[15:8] == KEY_G && b == KEY_R)
                    ? ALPHA_CLEAR : ALPHA_OPAQUE;
            value       = {alpha, b, color_lo};
            color_phase = PIX_BLUE;
        end

        // a total of zero counts as one, and a total already passed leaves one pixel
        eff_total = (total_q == '0) ? 32'd1 : total_q;
        remaining = (position >= eff_total) ? 32'd1 : eff_total - position;

        if (run_packet)
        begin
            if ({24'd0, packet_left} > remaining)
            begin
                reps    = remaining;
                clipped = 1'b1;
            end
            else
            begin
                reps    = {24'd0, packet_left};
                clipped = 1'b0;
            end
            packet_left = 8'd0;
        end
        else
        begin
            reps        = 32'd1;
            clipped     = (remaining == 32'd1 && packet_left > 8'd1);
            packet_left = packet_left - 8'd1;
        end
        last = (reps == remaining);

        res.pixel_value    = value;
        res.repeat_count   = reps[COUNT_W-1:0];
        res.first_position = position;
        res.image_done     = last;
        res.overrun        = clipped;
        expected_pixels.insert(expected_pixels.size(), res);

        if (last)
        begin
            position    = '0;
            packet_left = 8'd0;
            want_header = 1'b1;
        end
        else
        begin
            position = position + reps;
            if (packet_left == 8'd0)
                want_header = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_header = 1'b1;
            run_packet  = 1'b0;
            packet_left = 8'd0;
            color_phase = PIX_BLUE;
            color_lo    = 16'd0;
            position    = '0;
            mode_q      = MODE_TRUECOLOR;
            total_q     = PIXEL_TOTAL_RESET;
            errors      = 0;
            expected_pixels.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == CFG_PIXEL_MODE)
                    mode_q = cfg_data[0];
                else
                    total_q = cfg_data;
            end
            if (byte_valid && !byte_stall)
                decode_byte(data_byte);
            fail_count <= errors;
            pending    <= expected_pixels.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import tgarle_pkg::*;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = CFG_PIXEL_MODE;
    logic [WORD_W-1:0]   cfg_data     = '0;
    logic                byte_valid   = 1'b0;
    logic                byte_stall;
    logic [BYTE_W-1:0]   data_byte    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [WORD_W-1:0]   pixel_value;
    logic [COUNT_W-1:0]  repeat_count;
    logic [WORD_W-1:0]   first_position;
    logic                image_done;
    logic                overrun;

    int   fail_count;
    int   pending;
    int   hold_ticket = 0;
    int   items_sent  = 0;
    int   burst_left  = 0;
    logic gaps_on     = 1'b0;
    logic cur_mode    = MODE_TRUECOLOR;

    tga_rle_pixel_decoder_core dut (.*);

    tga_rle_checker scoreboard (.*);

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: stall density changes after each random span, long hold on request
    initial
    begin : receiver
        int span;
        int pct;
        int held;
        int hold_served;
        hold_served = 0;
        forever
        begin
            span = $urandom_range(32, 400);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 30;
                2: pct = 60;
                default: pct = 90;
            endcase
            repeat (span)
            begin
                @(posedge clk);
                if (hold_ticket != hold_served)
                begin
                    hold_served = hold_ticket;
                    result_stall <= 1'b1;
                    for (held = 0; held < 300; held++)
                        @(posedge clk);
                end
                result_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_packet_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 4);
        else if (r < 92)
            return $urandom_range(5, 24);
        else
            return $urandom_range(100, 128);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (byte_stall);
        items_sent++;
    endtask

    task automatic send_pixel();
        if (cur_mode == MODE_INDEXED)
        begin
            send_byte(pick_byte());
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            send_byte(KEY_B);
            send_byte(KEY_G);
            send_byte(KEY_R);
        end
        else
        begin
            send_byte(pick_byte());
            send_byte(pick_byte());
            send_byte(pick_byte());
        end
    endtask

    task automatic send_packet(input logic run, input int len);
        logic [6:0] len_field;
        len_field = 7'(len - 1);
        send_byte({run, len_field});
        if (run)
            send_pixel();
        else
            repeat (len) send_pixel();
    endtask

    // sender stops and waits until every expected result is out
    task automatic wait_for_idle();
        byte_valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_config(input logic mode, input logic [WORD_W-1:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PIXEL_MODE;
        cfg_data  <= {31'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_PIXEL_TOTAL;
        cfg_data  <= total;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_mode = mode;
    endtask

    initial
    begin
        int   phase;
        int   phase_end;
        int   pick;
        logic mode;
        logic [WORD_W-1:0] total;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: truecolor raw pair with the key color and all ones
        send_byte(8'h01);
        send_byte(KEY_B);
        send_byte(KEY_G);
        send_byte(KEY_R);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // longest run
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);

        // total now below the pixels already done, then a run past the end
        wait_for_idle();
        load_config(MODE_INDEXED, 32'd3);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // raw packet clipped at the image end, leftover byte read as a header
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hAB);
        send_byte(8'h00);
        send_byte(8'h55);
        // run that fits the rest exactly
        send_byte(8'h81);
        send_byte(8'h00);

        // zero total acts as one pixel
        wait_for_idle();
        load_config(MODE_TRUECOLOR, 32'd0);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);

        // mode switched after the blue byte of a pixel
        wait_for_idle();
        load_config(MODE_TRUECOLOR, 32'd10);
        send_byte(8'h03);
        send_byte(8'h11);
        wait_for_idle();
        load_config(MODE_INDEXED, 32'd10);
        send_byte(8'h22);
        // raw packet with the total lowered mid-image
        wait_for_idle();
        load_config(MODE_INDEXED, 32'd0);
        send_byte(8'h33);

        for (phase = 0; phase < 10; phase++)
        begin
            wait_for_idle();
            case (phase)
                0:
                begin
                    mode  = MODE_TRUECOLOR;
                    total = 32'd1;
                end
                1:
                begin
                    mode  = MODE_INDEXED;
                    total = 32'd4294836225;
                end
                2:
                begin
                    mode  = MODE_TRUECOLOR;
                    total = 32'hFFFF_FFFF;
                end
                3:
                begin
                    mode  = MODE_INDEXED;
                    total = 32'd1000;
                end
                default:
                begin
                    mode = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 7) == 0)
                        total = $urandom();
                    else
                        total = $urandom_range(1, 64);
                end
            endcase
            load_config(mode, total);
            gaps_on = (phase % 3) != 0;
            // output held off while bytes keep coming, so the input backs up
            if (phase == 3)
                hold_ticket <= hold_ticket + 1;
            phase_end = items_sent + 182;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                else if (pick < 12)
                begin
                    wait_for_idle();
                end
                else
                begin
                    send_packet(1'($urandom_range(0, 1)), pick_packet_len());
                end
            end
        end

        wait_for_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
